// ===== hdl/keypad_scan_debounce_defines.svh =====
// Assertion macros for the keypad scanner and debounce block.
// Included by the top level; uses its aclk and aresetn.
`ifndef KEYPAD_SCAN_DEBOUNCE_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCE_DEFINES_SVH

// Check a property while out of reset
`define KSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every edge, reset included
`define KSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/ksd_pkg.sv =====
// Shared types, codes and tables for the keypad scanner and debounce block.
// No dependencies.
package ksd_pkg;

    // Key code for "no key"
    localparam logic [3:0] KEY_NONE = 4'd12;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_BEEP_LENGTH    = 2'd1;

    // Reset values of the configuration registers
    localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd5;
    localparam logic [15:0] BEEP_LENGTH_RST    = 16'd50;

    // Drive lines for "no row selected"
    localparam logic [2:0] DRIVE_NONE = 3'b111;

    // Scan phases
    typedef enum logic [2:0] {
        PH_DRIVE = 3'd0,
        PH_ROW1  = 3'd1,
        PH_ROW2  = 3'd2,
        PH_ROW3  = 3'd3,
        PH_EVAL  = 3'd4
    } phase_t;

    // Key code of each matrix slot, row-major: cancel,7,4,1 / 0,8,5,2 / enter,9,6,3
    localparam logic [3:0] KEY_OF_SLOT [12] = '{
        4'd10, 4'd7, 4'd4, 4'd1,
        4'd0,  4'd8, 4'd5, 4'd2,
        4'd11, 4'd9, 4'd6, 4'd3
    };

    // Row drive lines for the tick after the given phase
    function automatic logic [2:0] drive_after(input phase_t ph);
        logic [2:0] drv;
        unique case (ph)
            PH_DRIVE: drv = 3'b110;
            PH_ROW1:  drv = 3'b101;
            PH_ROW2:  drv = 3'b011;
            default:  drv = DRIVE_NONE;
        endcase
        return drv;
    endfunction

    // Highest key code among the set bits; enter wins over cancel over digits
    function automatic logic [3:0] highest_code(input logic [11:0] keys);
        logic [3:0] code;
        code = KEY_NONE;
        for (int k = 0; k < 12; k++) begin
            if (keys[k]) code = 4'(k);
        end
        return code;
    endfunction

endpackage

// ===== hdl/ksd_integ.sv =====
// One key integrator with its debounced bit.
// Standalone; instantiated once per matrix slot by the top level.
module ksd_integ #(
    parameter int INTEGRATOR_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic       pressed,
    input  logic [7:0] limit,
    output logic       deb,
    output logic       deb_next
);

    localparam int CW = (INTEGRATOR_BITS > 8) ? INTEGRATOR_BITS : 8;
    localparam logic [CW-1:0] COUNT_MAX = CW'((1 << INTEGRATOR_BITS) - 1);

    logic [INTEGRATOR_BITS-1:0] count_reg, count_next;
    logic                       deb_reg;
    logic [CW-1:0]              lim_wide, lim_eff;

    // Saturate the limit to the counter range
    always_comb begin
        lim_wide = CW'(limit);
        lim_eff  = (lim_wide > COUNT_MAX) ? COUNT_MAX : lim_wide;
    end

    // Count towards the reading; move the debounced bit only at the ends
    always_comb begin
        count_next = count_reg;
        deb_next   = deb_reg;
        if (step_en) begin
            if (!pressed) begin
                if (count_reg != '0) count_next = count_reg - 1'b1;
                else deb_next = 1'b0;
            end else begin
                if (CW'(count_reg) < lim_eff) count_next = count_reg + 1'b1;
                else deb_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            deb_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            deb_reg   <= deb_next;
        end
    end

    assign deb = deb_reg;

endmodule

// ===== hdl/keypad_scan_debounce.sv =====
// Channel   Direction  Words
// s_        in         one column sample per scan tick
// m_        out        one status word per tick
// cfg_      in         register writes (index 0 limit, 1 beep length)
// One tick is taken per clock; the status word is ready the cycle after.
// The output register frees while the next word comes in, so ticks flow at one per cycle.
// A stalled m_ side holds the word and blocks s_ only while that word waits.
// Reset (aresetn low, synchronous) clears scan state, integrators and timers.
// Depends on ksd_pkg, ksd_integ and keypad_scan_debounce_defines.svh.
`include "keypad_scan_debounce_defines.svh"

module keypad_scan_debounce
    import ksd_pkg::*;
#(
    parameter int INTEGRATOR_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // scan tick input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_column_lines,
    // status output
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_row_drive,
    output logic [11:0] m_raw_matrix,
    output logic [11:0] m_debounced_keys,
    output logic        m_key_event,
    output logic [3:0]  m_last_key,
    output logic [3:0]  m_previous_key,
    output logic        m_beep_active,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        s_accept;
    logic        cfg_write;

    logic [7:0]  limit_reg;
    logic [15:0] beep_len_reg;

    phase_t      phase_reg, phase_next;
    logic [11:0] raw_reg, raw_next;
    logic [11:0] prev_deb_reg, prev_deb_next;
    logic [3:0]  latest_reg, latest_next;
    logic [3:0]  earlier_reg, earlier_next;
    logic [15:0] beep_reg, beep_next, beep_dec;

    logic [3:0]  pressed_cols;
    logic [11:0] deb_slot, deb_slot_next;
    logic [11:0] deb_vec, deb_vec_next;
    logic [11:0] fresh;
    logic        event_next;

    logic        m_valid_reg;
    logic [2:0]  drive_reg;
    logic [11:0] raw_out_reg, deb_out_reg;
    logic        event_reg;
    logic [3:0]  last_out_reg, prev_out_reg;
    logic        beep_out_reg;

    // Take a word whenever the output register is free or being emptied
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= DEBOUNCE_LIMIT_RST;
            beep_len_reg <= BEEP_LENGTH_RST;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_DEBOUNCE_LIMIT: limit_reg    <= cfg_data[7:0];
                CFG_BEEP_LENGTH:    beep_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign pressed_cols = ~s_column_lines;

    // Integrators: only the row sampled in this phase steps
    for (genvar g = 0; g < 12; g++) begin : g_slot
        ksd_integ #(
            .INTEGRATOR_BITS(INTEGRATOR_BITS)
        ) u_integ (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step_en  (s_accept && (phase_reg == phase_t'(3'(g / 4 + 1)))),
            .pressed  (pressed_cols[g % 4]),
            .limit    (limit_reg),
            .deb      (deb_slot[g]),
            .deb_next (deb_slot_next[g])
        );
        assign deb_vec[KEY_OF_SLOT[g]]      = deb_slot[g];
        assign deb_vec_next[KEY_OF_SLOT[g]] = deb_slot_next[g];
    end

    // Advance the scan phase
    always_comb begin
        unique case (phase_reg)
            PH_DRIVE: phase_next = PH_ROW1;
            PH_ROW1:  phase_next = PH_ROW2;
            PH_ROW2:  phase_next = PH_ROW3;
            PH_ROW3:  phase_next = PH_EVAL;
            default:  phase_next = PH_DRIVE;
        endcase
    end

    // Replace the sampled row in the raw matrix
    always_comb begin
        case (phase_reg)
            PH_ROW1: raw_next = {raw_reg[11:4], pressed_cols};
            PH_ROW2: raw_next = {raw_reg[11:8], pressed_cols, raw_reg[3:0]};
            PH_ROW3: raw_next = {pressed_cols, raw_reg[7:0]};
            default: raw_next = raw_reg;
        endcase
    end

    // Find new presses, record the winner and start the beep if idle
    always_comb begin
        fresh         = deb_vec & ~prev_deb_reg;
        event_next    = (phase_reg == PH_EVAL) && (fresh != '0);
        prev_deb_next = (phase_reg == PH_EVAL) ? deb_vec : prev_deb_reg;
        beep_dec      = (beep_reg != '0) ? beep_reg - 16'd1 : beep_reg;
        latest_next   = latest_reg;
        earlier_next  = earlier_reg;
        beep_next     = beep_dec;
        if (event_next) begin
            latest_next  = highest_code(fresh);
            earlier_next = latest_reg;
            if (beep_dec == '0) beep_next = beep_len_reg;
        end
    end

    // Scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_DRIVE;
            raw_reg      <= '0;
            prev_deb_reg <= '0;
            latest_reg   <= KEY_NONE;
            earlier_reg  <= KEY_NONE;
            beep_reg     <= '0;
        end else if (s_accept) begin
            phase_reg    <= phase_next;
            raw_reg      <= raw_next;
            prev_deb_reg <= prev_deb_next;
            latest_reg   <= latest_next;
            earlier_reg  <= earlier_next;
            beep_reg     <= beep_next;
        end
    end

    // Output register: valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register: payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            drive_reg    <= drive_after(phase_reg);
            raw_out_reg  <= raw_next;
            deb_out_reg  <= deb_vec_next;
            event_reg    <= event_next;
            last_out_reg <= latest_next;
            prev_out_reg <= earlier_next;
            beep_out_reg <= (beep_next != '0);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_row_drive      = drive_reg;
    assign m_raw_matrix     = raw_out_reg;
    assign m_debounced_keys = deb_out_reg;
    assign m_key_event      = event_reg;
    assign m_last_key       = last_out_reg;
    assign m_previous_key   = prev_out_reg;
    assign m_beep_active    = beep_out_reg;

    `KSD_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_valid, "output valid after reset")
    `KSD_ASSERT(a_accept_fills, s_valid && s_ready |=> m_valid, "accepted tick gave no word")
    `KSD_ASSERT(a_event_has_key, m_valid && m_key_event |-> m_last_key != KEY_NONE,
                "key event without a key code")
    `KSD_ASSERT(a_event_rows_free, m_valid && m_key_event |-> m_row_drive == DRIVE_NONE,
                "key event outside the evaluation phase")

endmodule

// ===== tb/sv/keypad_status_checker.sv =====
// Status-word scoreboard for the keypad scanner: watches the s_, m_ and cfg_ channels,
// predicts one status word per scan tick and compares it field by field.
// Depends on ksd_pkg for the scan phase type and the key and drive codes.
module keypad_status_checker
    import ksd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [3:0]  s_column_lines,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_row_drive,
    input  logic [11:0] m_raw_matrix,
    input  logic [11:0] m_debounced_keys,
    input  logic        m_key_event,
    input  logic [3:0]  m_last_key,
    input  logic [3:0]  m_previous_key,
    input  logic        m_beep_active,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          mismatches,
    output int          words_pending
);

    typedef struct packed {
        logic [2:0]  row_drive;
        logic [11:0] raw_matrix;
        logic [11:0] debounced_keys;
        logic        key_event;
        logic [3:0]  last_key;
        logic [3:0]  previous_key;
        logic        beep_active;
    } status_word_t;

    localparam logic [7:0]  LIMIT_AT_RESET = 8'd5;
    localparam logic [15:0] BEEP_AT_RESET  = 16'd50;
    // Key code wired to each matrix position, row by row
    localparam logic [3:0]  CODE_AT [12] = '{
        4'd10, 4'd7, 4'd4, 4'd1,
        4'd0,  4'd8, 4'd5, 4'd2,
        4'd11, 4'd9, 4'd6, 4'd3
    };

    // Register copies and scanner state
    logic [7:0]   limit_reg;
    logic [15:0]  beep_len_reg;
    phase_t       phase;
    logic [7:0]   integ [12];
    logic [11:0]  held_keys;
    logic [11:0]  seen_keys;
    logic [11:0]  raw_keys;
    logic [3:0]   latest;
    logic [3:0]   earlier;
    logic [15:0]  beep_left;

    status_word_t expected_words [$];
    status_word_t want_w;
    int           err_count;

    // Advance the scanner by one tick and return the status word it should emit
    task automatic predict_tick(input logic [3:0] cols, output status_word_t w);
        logic [3:0]  pressed;
        logic [11:0] fresh;
        int          row;
        int          slot;
        w = '0;
        if (beep_left != 0) beep_left--;
        case (phase)
            PH_ROW1, PH_ROW2, PH_ROW3: begin
                row = int'(phase) - 1;
                pressed = ~cols;
                raw_keys[row*4 +: 4] = pressed;
                // integrate: count towards the limit, flip the key only at either end
                for (int c = 0; c < 4; c++) begin
                    slot = row * 4 + c;
                    if (!pressed[c]) begin
                        if (integ[slot] != 0) integ[slot]--;
                        else held_keys[CODE_AT[slot]] = 1'b0;
                    end else if (integ[slot] < limit_reg) begin
                        integ[slot]++;
                    end else begin
                        held_keys[CODE_AT[slot]] = 1'b1;
                    end
                end
            end
            PH_EVAL: begin
                fresh = held_keys & ~seen_keys;
                seen_keys = held_keys;
                if (fresh != 0) begin
                    // highest code wins: enter, then cancel, then digits downwards
                    earlier = latest;
                    for (int k = 0; k < 12; k++) begin
                        if (fresh[k]) latest = 4'(k);
                    end
                    if (beep_left == 0) beep_left = beep_len_reg;
                    w.key_event = 1'b1;
                end
            end
            default: ;
        endcase
        case (phase)
            PH_DRIVE: w.row_drive = 3'b110;
            PH_ROW1:  w.row_drive = 3'b101;
            PH_ROW2:  w.row_drive = 3'b011;
            default:  w.row_drive = DRIVE_NONE;
        endcase
        phase = (phase == PH_EVAL) ? PH_DRIVE : phase_t'(phase + 1);
        w.raw_matrix     = raw_keys;
        w.debounced_keys = held_keys;
        w.last_key       = latest;
        w.previous_key   = earlier;
        w.beep_active    = (beep_left != 0);
    endtask

    task automatic check_field(input string label, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            err_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            // drop all state back to its power-on values
            limit_reg    = LIMIT_AT_RESET;
            beep_len_reg = BEEP_AT_RESET;
            phase        = PH_DRIVE;
            for (int i = 0; i < 12; i++) integ[i] = '0;
            held_keys    = '0;
            seen_keys    = '0;
            raw_keys     = '0;
            latest       = KEY_NONE;
            earlier      = KEY_NONE;
            beep_left    = '0;
            expected_words.delete();
        end else begin
            // compare the outgoing word with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    err_count++;
                    $display("%0t: status word expected none, got one (last_key %0d)",
                             $time, m_last_key);
                end else begin
                    want_w = expected_words.pop_front();
                    check_field("row_drive", 12'(want_w.row_drive), 12'(m_row_drive));
                    check_field("raw_matrix", want_w.raw_matrix, m_raw_matrix);
                    check_field("debounced_keys", want_w.debounced_keys, m_debounced_keys);
                    check_field("key_event", 12'(want_w.key_event), 12'(m_key_event));
                    check_field("last_key", 12'(want_w.last_key), 12'(m_last_key));
                    check_field("previous_key", 12'(want_w.previous_key),
                                12'(m_previous_key));
                    check_field("beep_active", 12'(want_w.beep_active), 12'(m_beep_active));
                end
            end
            // hold register writes; unused indexes leave everything alone
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEBOUNCE_LIMIT: limit_reg = cfg_data[7:0];
                    CFG_BEEP_LENGTH:    beep_len_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_tick(s_column_lines, want_w);
                expected_words.push_back(want_w);
            end
        end
        mismatches    <= err_count;
        words_pending <= expected_words.size();
    end

endmodule

// ===== tb/sv/keypad_scan_debounce_tb.sv =====
// Top of the keypad scanner testbench: makes scan ticks from simulated key presses
// with bounce, writes the registers between phases, stalls both sides and gives the verdict.
// Depends on ksd_pkg, keypad_scan_debounce and keypad_status_checker.
module keypad_scan_debounce_tb;
    import ksd_pkg::*;

    localparam int          STUCK_LIMIT  = 1000;
    localparam int          LONG_HOLD    = 200;
    localparam int          BOUNCE_NOISE = 500;
    localparam logic [1:0]  CFG_SPARE_A  = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B  = 2'd3;
    // Key sets for the opening patterns: all, none, cancel alone, 0 with 9, none
    localparam logic [11:0] OPENING_KEYS [5] = '{12'hFFF, 12'h000, 12'h001, 12'h210, 12'h000};

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [3:0]  s_column_lines;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_row_drive;
    logic [11:0] m_raw_matrix;
    logic [11:0] m_debounced_keys;
    logic        m_key_event;
    logic [3:0]  m_last_key;
    logic [3:0]  m_previous_key;
    logic        m_beep_active;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int mismatches;
    int words_pending;
    int tick_no;
    int stuck_cycles;
    bit tx_jitter;
    bit rx_jitter;
    bit rx_hold_req;
    bit calm;

    keypad_scan_debounce uut (.*);

    keypad_status_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Column lines for the next tick: keys of the scanned row, with bounce flips
    function automatic logic [3:0] column_sample(input logic [11:0] keys, input int bounce_pm);
        logic [3:0] pressed;
        int         row;
        row = tick_no % 5 - 1;
        if (row < 0 || row > 2) return 4'($urandom);
        pressed = keys[row*4 +: 4];
        for (int c = 0; c < 4; c++) begin
            if ($urandom_range(0, 999) < bounce_pm) pressed[c] = ~pressed[c];
        end
        return ~pressed;
    endfunction

    // Offer one tick word, hold it until taken, then maybe pause
    task automatic send_tick(input logic [3:0] cols);
        s_valid <= 1'b1;
        s_column_lines <= cols;
        do @(posedge aclk); while (!s_ready);
        tick_no++;
        if (tx_jitter && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    // Stop offering ticks and wait until every predicted word has come back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Load a new setting while idle; spare indexes must be ignored
    task automatic configure(input logic [7:0] lim, input logic [15:0] beep_len, input bit spare);
        wait_drained();
        if (spare) write_reg(CFG_SPARE_A, 16'h0001);
        write_reg(CFG_DEBOUNCE_LIMIT, {8'h00, lim});
        write_reg(CFG_BEEP_LENGTH, beep_len);
        if (spare) write_reg(CFG_SPARE_B, 16'hAAAA);
        cfg_valid <= 1'b0;
    endtask

    // Press and release episodes long enough to pass the debounce limit
    task automatic key_episodes(input int lim, input int n_ticks);
        int          stop_at;
        int          span;
        int          bounce;
        logic [11:0] keys;
        stop_at = tick_no + n_ticks;
        while (tick_no < stop_at) begin
            if (!calm) begin
                tx_jitter = ($urandom_range(0, 3) != 0);
                rx_jitter = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: keys = 12'b1 << $urandom_range(0, 11);
                5, 6:          keys = 12'($urandom);
                7:             keys = '1;
                default:       keys = '0;
            endcase
            bounce = ($urandom_range(0, 9) == 0) ? BOUNCE_NOISE : $urandom_range(0, 120);
            span = (lim + 2) * 5 + $urandom_range(0, 25);
            for (int i = 0; i < span && tick_no < stop_at; i++)
                send_tick(column_sample(keys, bounce));
            span = (lim + 2) * 5 + $urandom_range(0, 10);
            for (int i = 0; i < span && tick_no < stop_at; i++)
                send_tick(column_sample('0, $urandom_range(0, 60)));
        end
    endtask

    // Status side: random stall bursts, and one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (rx_jitter && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // End the run when no word moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        s_valid <= 1'b0;
        s_column_lines <= 4'h0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_DEBOUNCE_LIMIT;
        cfg_data <= 16'h0000;
        aresetn <= 1'b0;
        tick_no = 0;
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        rx_hold_req = 1'b0;
        calm = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // limit zero: keys follow the raw reading; all keys at once must give enter
        configure(8'd0, 16'd3, 1'b1);
        for (int p = 0; p < 5; p++) begin
            repeat (5) send_tick(column_sample(OPENING_KEYS[p], 0));
        end

        configure(8'd1, 16'd0, 1'b0);
        key_episodes(1, 250);
        configure(8'd5, 16'd50, 1'b0);
        key_episodes(5, 300);
        configure(8'd255, 16'hFFFF, 1'b0);
        key_episodes(255, 150);

        // long stall on the status side while ticks keep coming
        configure(8'd2, 16'd7, 1'b1);
        rx_hold_req = 1'b1;
        key_episodes(2, 300);

        configure(8'd3, 16'd20, 1'b0);
        key_episodes(3, 225);
        calm = 1'b1;
        tx_jitter = 1'b0;
        rx_jitter = 1'b0;
        key_episodes(3, 200);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
